>>> hdl/sfcd_pkg.sv
// Shared types and constants for the sync-framed command deframer.
`timescale 1ns / 1ps
`default_nettype none

package sfcd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_FIRST_SYNC  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SECOND_SYNC = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_THIRD_SYNC  = 2'd2;

  // Frame phase, one-hot
  typedef enum logic [8:0] {
    PH_HUNT    = 9'b000000001,
    PH_SYNC2   = 9'b000000010,
    PH_SYNC3   = 9'b000000100,
    PH_CMD     = 9'b000001000,
    PH_DATA_HI = 9'b000010000,
    PH_DATA_LO = 9'b000100000,
    PH_REG     = 9'b001000000,
    PH_CSUM_HI = 9'b010000000,
    PH_CSUM_LO = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [ByteW-1:0] first_sync;
    logic [ByteW-1:0] second_sync;
    logic [ByteW-1:0] third_sync;
  } sync_cfg_t;

  // Packs into tdata as {payload_word, register_index, command_code}
  typedef struct packed {
    logic [WordW-1:0] payload_word;
    logic [ByteW-1:0] register_index;
    logic [ByteW-1:0] command_code;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/sfcd_parser.sv
// Frame parser: phase tracking, field capture and checksum check.
`timescale 1ns / 1ps
`default_nettype none

module sfcd_parser (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       step,      // consume rx_byte this cycle
  input  wire [sfcd_pkg::ByteW-1:0] rx_byte,
  input  sfcd_pkg::sync_cfg_t       sync_cfg,
  output logic                      hit,       // rx_byte would complete a good frame
  output sfcd_pkg::result_t         result
);

  sfcd_pkg::phase_t phase, phase_next;
  logic [sfcd_pkg::ByteW-1:0] held_command;
  logic [sfcd_pkg::ByteW-1:0] held_register;
  logic [sfcd_pkg::WordW-1:0] held_data;
  logic [sfcd_pkg::ByteW-1:0] held_checksum_high;
  logic [sfcd_pkg::WordW-1:0] sum;

  // 7 bytes fit in 11 bits; carry into 16 bits.
  assign sum = {8'd0, sync_cfg.first_sync} + {8'd0, sync_cfg.second_sync}
             + {8'd0, sync_cfg.third_sync} + {8'd0, held_command}
             + {8'd0, held_register} + {8'd0, held_data[15:8]}
             + {8'd0, held_data[7:0]};

  assign hit = (phase == sfcd_pkg::PH_CSUM_LO) && (sum == {held_checksum_high, rx_byte});

  assign result.command_code   = held_command;
  assign result.register_index = held_register;
  assign result.payload_word   = held_data;

  always_comb begin
    case (phase)
      sfcd_pkg::PH_SYNC2:
        phase_next = (rx_byte == sync_cfg.second_sync) ? sfcd_pkg::PH_SYNC3 : sfcd_pkg::PH_HUNT;
      sfcd_pkg::PH_SYNC3:
        phase_next = (rx_byte == sync_cfg.third_sync) ? sfcd_pkg::PH_CMD : sfcd_pkg::PH_HUNT;
      sfcd_pkg::PH_CMD:     phase_next = sfcd_pkg::PH_DATA_HI;
      sfcd_pkg::PH_DATA_HI: phase_next = sfcd_pkg::PH_DATA_LO;
      sfcd_pkg::PH_DATA_LO: phase_next = sfcd_pkg::PH_REG;
      sfcd_pkg::PH_REG:     phase_next = sfcd_pkg::PH_CSUM_HI;
      sfcd_pkg::PH_CSUM_HI: phase_next = sfcd_pkg::PH_CSUM_LO;
      sfcd_pkg::PH_CSUM_LO: phase_next = sfcd_pkg::PH_HUNT;
      default:
        phase_next = (rx_byte == sync_cfg.first_sync) ? sfcd_pkg::PH_SYNC2 : sfcd_pkg::PH_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= sfcd_pkg::PH_HUNT;
      held_command       <= '0;
      held_register      <= '0;
      held_data          <= '0;
      held_checksum_high <= '0;
    end else if (step) begin
      phase <= phase_next;
      if (phase == sfcd_pkg::PH_CMD)     held_command       <= rx_byte;
      if (phase == sfcd_pkg::PH_DATA_HI) held_data[15:8]    <= rx_byte;
      if (phase == sfcd_pkg::PH_DATA_LO) held_data[7:0]     <= rx_byte;
      if (phase == sfcd_pkg::PH_REG)     held_register      <= rx_byte;
      if (phase == sfcd_pkg::PH_CSUM_HI) held_checksum_high <= rx_byte;
    end
  end

endmodule

`default_nettype wire

>>> hdl/sfcd_out_reg.sv
// Result register driving the master-side stream.
`timescale 1ns / 1ps
`default_nettype none

module sfcd_out_reg (
  input  wire                clk,
  input  wire                rst,
  input  wire                load,
  input  sfcd_pkg::result_t  load_data,
  output logic               free,       // register can take a result this cycle
  output logic               m_tvalid,
  input  wire                m_tready,
  output sfcd_pkg::result_t  m_result
);

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_result <= load_data;
    end
  end

endmodule

`default_nettype wire

>>> hdl/sync_framed_command_deframer.sv
// Top level of the sync-framed command deframer.
`timescale 1ns / 1ps
`default_nettype none

// Finds nine-byte command frames in a received byte stream: three sync bytes
// (matched against the three sync registers), command, data high, data low,
// register, then a 16-bit checksum sent high byte first. The checksum is the
// 16-bit sum of the three sync register values and the four payload bytes;
// a good frame produces one beat on the master side, a bad one produces
// nothing. A sync mismatch returns the parser to hunting for the first sync
// byte and the mismatching byte is not retried as a first sync byte.
// Rate: one byte per cycle. Each byte lands in an input register and is
// consumed by the parser from there; the result register holds a finished
// frame while later bytes keep flowing. The input only stalls when the byte
// completing a good frame finds the result register still full. A good
// frame is loaded there as its last checksum byte leaves the input register.
// Config writes are always accepted (cfg_ready is tied high); write them only
// while no frame is in flight. Indexes beyond the third register are ignored.

module sync_framed_command_deframer (
  input  wire         clk,
  input  wire         rst,
  // slave side
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,     // [7:0] rx_byte
  // master side
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,     // [7:0] command_code, [15:8] register_index,
                                   // [31:16] payload_word
  // config write channel
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [7:0]  cfg_data
);

  sfcd_pkg::sync_cfg_t sync_cfg;
  sfcd_pkg::result_t   parse_result;
  sfcd_pkg::result_t   out_result;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       hit;
  logic       out_free;
  logic       advance;

  // Config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        sfcd_pkg::REG_FIRST_SYNC:  sync_cfg.first_sync  <= cfg_data;
        sfcd_pkg::REG_SECOND_SYNC: sync_cfg.second_sync <= cfg_data;
        sfcd_pkg::REG_THIRD_SYNC:  sync_cfg.third_sync  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register; the held byte moves on unless it completes a good frame
  // and the result register is still occupied.
  assign advance  = in_valid && (out_free || !hit);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  sfcd_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .rx_byte  (in_byte),
    .sync_cfg (sync_cfg),
    .hit      (hit),
    .result   (parse_result)
  );

  sfcd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && hit),
    .load_data (parse_result),
    .free      (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_result  (out_result)
  );

  assign m_tdata = out_result;

endmodule

`default_nettype wire

>>> tb/sv/sfcd_frame_checker.sv
// Beat monitor, frame predictor and result comparator for the command deframer.
`timescale 1ns / 1ps

module sfcd_frame_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  input  wire         s_tready,
  input  wire  [7:0]  s_tdata,     // [7:0] rx_byte
  input  wire         m_tvalid,
  input  wire         m_tready,
  input  wire  [31:0] m_tdata,     // [7:0] command_code, [15:8] register_index,
                                   // [31:16] payload_word
  input  wire         cfg_valid,
  input  wire         cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [7:0]  cfg_data,
  output int unsigned fail_count,
  output int unsigned pending
);

  sfcd_pkg::sync_cfg_t sync_regs;
  sfcd_pkg::phase_t    phase;
  logic [7:0]          cmd_hold;
  logic [7:0]          reg_hold;
  logic [7:0]          csum_hi_hold;
  logic [15:0]         data_hold;
  sfcd_pkg::result_t   frames_due[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  // Advance the frame parser by one received byte.
  function automatic void parse_byte(input logic [7:0] b);
    logic [15:0]       sum;
    sfcd_pkg::result_t frame;
    case (phase)
      sfcd_pkg::PH_SYNC2:
        phase = (b == sync_regs.second_sync) ? sfcd_pkg::PH_SYNC3 : sfcd_pkg::PH_HUNT;
      sfcd_pkg::PH_SYNC3:
        phase = (b == sync_regs.third_sync) ? sfcd_pkg::PH_CMD : sfcd_pkg::PH_HUNT;
      sfcd_pkg::PH_CMD: begin
        cmd_hold = b;
        phase = sfcd_pkg::PH_DATA_HI;
      end
      sfcd_pkg::PH_DATA_HI: begin
        data_hold[15:8] = b;
        phase = sfcd_pkg::PH_DATA_LO;
      end
      sfcd_pkg::PH_DATA_LO: begin
        data_hold[7:0] = b;
        phase = sfcd_pkg::PH_REG;
      end
      sfcd_pkg::PH_REG: begin
        reg_hold = b;
        phase = sfcd_pkg::PH_CSUM_HI;
      end
      sfcd_pkg::PH_CSUM_HI: begin
        csum_hi_hold = b;
        phase = sfcd_pkg::PH_CSUM_LO;
      end
      sfcd_pkg::PH_CSUM_LO: begin
        // sync registers as they stand now, not when the syncs arrived
        sum = 16'(sync_regs.first_sync) + 16'(sync_regs.second_sync)
            + 16'(sync_regs.third_sync) + 16'(cmd_hold) + 16'(reg_hold)
            + 16'(data_hold[15:8]) + 16'(data_hold[7:0]);
        if (sum == {csum_hi_hold, b}) begin
          frame.command_code   = cmd_hold;
          frame.register_index = reg_hold;
          frame.payload_word   = data_hold;
          frames_due.push_back(frame);
        end
        phase = sfcd_pkg::PH_HUNT;
      end
      default:
        phase = (b == sync_regs.first_sync) ? sfcd_pkg::PH_SYNC2 : sfcd_pkg::PH_HUNT;
    endcase
  endfunction

  function automatic void check_beat(input logic [31:0] beat);
    sfcd_pkg::result_t got;
    sfcd_pkg::result_t want;
    got = sfcd_pkg::result_t'(beat);
    if (frames_due.size() == 0) begin
      note_failure($sformatf("unexpected result beat cmd=%02h reg=%02h data=%04h",
                             got.command_code, got.register_index, got.payload_word));
    end else begin
      want = frames_due.pop_front();
      if (got.command_code !== want.command_code ||
          got.register_index !== want.register_index ||
          got.payload_word !== want.payload_word) begin
        note_failure($sformatf({"result mismatch: cmd exp %02h got %02h, ",
                                "reg exp %02h got %02h, data exp %04h got %04h"},
                               want.command_code, got.command_code,
                               want.register_index, got.register_index,
                               want.payload_word, got.payload_word));
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      sync_regs    = '0;
      phase        = sfcd_pkg::PH_HUNT;
      cmd_hold     = '0;
      reg_hold     = '0;
      csum_hi_hold = '0;
      data_hold    = '0;
      frames_due.delete();
    end else begin
      if (m_tvalid && m_tready) check_beat(m_tdata);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sfcd_pkg::REG_FIRST_SYNC:  sync_regs.first_sync  = cfg_data;
          sfcd_pkg::REG_SECOND_SYNC: sync_regs.second_sync = cfg_data;
          sfcd_pkg::REG_THIRD_SYNC:  sync_regs.third_sync  = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) parse_byte(s_tdata);
    end
    pending = frames_due.size();
  end

endmodule

>>> tb/sv/sync_framed_command_deframer_test.sv
// Top of the deframer testbench: clock, reset, byte stimulus, config writes, verdict.
`timescale 1ns / 1ps

module sync_framed_command_deframer_test;

  localparam int unsigned ITEMS        = 1550;  // rough byte budget for the run
  localparam int unsigned HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 6;     // covers the input and result registers
  localparam int unsigned QUIET_LIMIT  = 2000;  // cycles with no beat anywhere
  localparam logic [1:0]  REG_UNUSED   = 2'd3;  // index past the last register

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned bytes_sent;
  int unsigned quiet_cycles;

  // shared between the sender and the receiver process
  bit gaps_on;
  bit hold_req;

  // sync values the sender believes are loaded, used to build frames
  logic [7:0] first_sync;
  logic [7:0] second_sync;
  logic [7:0] third_sync;

  sync_framed_command_deframer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sfcd_frame_checker frame_watch (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a stuck handshake anywhere ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  // One assignment to m_tready per falling edge at most.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 13)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offer one byte, optionally after an idle burst, and wait for its beat.
  // Valid is left high so the next byte can follow in the very next cycle.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  // Drop valid, wait for every pending result, then let the pipeline empty.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Only called with the block idle (see settle).
  task automatic write_sync(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      sfcd_pkg::REG_FIRST_SYNC:  first_sync  = val;
      sfcd_pkg::REG_SECOND_SYNC: second_sync = val;
      sfcd_pkg::REG_THIRD_SYNC:  third_sync  = val;
      default: ;
    endcase
  endtask

  task automatic set_syncs(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
    write_sync(sfcd_pkg::REG_FIRST_SYNC, a);
    write_sync(sfcd_pkg::REG_SECOND_SYNC, b);
    write_sync(sfcd_pkg::REG_THIRD_SYNC, c);
  endtask

  function automatic logic [15:0] frame_sum(input logic [7:0] cmd, input logic [7:0] dhi,
                                            input logic [7:0] dlo, input logic [7:0] rg);
    return 16'(first_sync) + 16'(second_sync) + 16'(third_sync)
         + 16'(cmd) + 16'(dhi) + 16'(dlo) + 16'(rg);
  endfunction

  // Send the first len bytes of a frame; corrupt flips checksum bits.
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] dhi,
                            input logic [7:0] dlo, input logic [7:0] rg,
                            input bit corrupt, input int unsigned len);
    logic [15:0] csum;
    logic [7:0]  frame_bytes [9];
    csum = frame_sum(cmd, dhi, dlo, rg);
    if (corrupt) csum = csum ^ 16'($urandom_range(1, 65535));
    frame_bytes = '{first_sync, second_sync, third_sync, cmd, dhi, dlo, rg,
                    csum[15:8], csum[7:0]};
    for (int i = 0; i < len; i++) send_byte(frame_bytes[i]);
  endtask

  initial begin
    int unsigned pick;
    logic [7:0]  same;
    logic [15:0] csum;

    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    gaps_on     = 1'b1;
    hold_req    = 1'b0;
    bytes_sent  = 0;
    first_sync  = '0;
    second_sync = '0;
    third_sync  = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // --- directed part ---
    // all-zero frame against the reset sync values
    send_frame(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 9);

    // all-ones syncs and payload; a write past the last register is ignored
    settle();
    set_syncs(8'hFF, 8'hFF, 8'hFF);
    write_sync(REG_UNUSED, 8'hFF);
    send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 9);

    // distinct syncs for the mismatch cases
    settle();
    set_syncs(8'hA5, 8'h5A, 8'hC3);
    // mismatch at the second sync: the byte is eaten, not retried as a first sync
    send_byte(8'hA5);
    send_byte(8'hA5);
    send_byte(8'h5A);
    // mismatch at the third sync
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'hA5);
    // bad checksum, dropped
    send_frame(8'h12, 8'h34, 8'h56, 8'h78, 1'b1, 9);

    // sync register rewritten mid-frame: checksum must use the new value
    send_frame(8'h81, 8'h00, 8'h00, 8'h00, 1'b0, 4);
    settle();
    write_sync(sfcd_pkg::REG_FIRST_SYNC, 8'h3C);
    csum = frame_sum(8'h81, 8'h7E, 8'h00, 8'hFF);
    send_byte(8'h7E);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(csum[15:8]);
    send_byte(csum[7:0]);

    // --- random part, five config phases ---
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        1: set_syncs(8'hFF, 8'h00, 8'hFF);
        3: begin
          // equal syncs: a mismatching byte can never also be a first sync
          same = 8'($urandom);
          set_syncs(same, same, same);
        end
        default: set_syncs(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      // idle bursts in phases 0, 2, 3; none in phase 1 nor the closing phase
      gaps_on = (ph == 0 || ph == 2 || ph == 3);

      if (ph == 2) begin
        // receiver holds off while good frames keep coming: the result
        // register fills and the input must stall
        hold_req = 1'b1;
        repeat (5)
          send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 9);
      end

      while (bytes_sent < (ph + 1) * ITEMS / 5) begin
        pick = $urandom_range(0, 99);
        if (pick < 65)
          send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 9);
        else if (pick < 77)
          send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b1, 9);
        else if (pick < 89)
          // truncated frame; the next bytes continue it from wherever it stopped
          send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0,
                     $urandom_range(1, 8));
        else
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end
    end

    // drain; the watchdog bounds this wait
    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
